// File: hw/rtl/fam_pkg.sv
package fam_pkg;

  localparam int SECTOR_BYTES = 256;
  localparam int SECTOR_TOTAL = 16;
  localparam int ALIGN_BYTES = 4;
  localparam int ARRAY_BYTES = SECTOR_BYTES * SECTOR_TOTAL;

  localparam int LANES = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS = ARRAY_BYTES / LANES;
  localparam int ROW_W = $clog2(ROWS);
  localparam int ROWS_PER_SECTOR = SECTOR_BYTES / LANES;
  localparam int SECT_OFF_W = $clog2(SECTOR_BYTES);

  localparam int OP_W = 2;
  localparam int ADDR_W = 12;
  localparam int COUNT_W = 5;
  localparam int DATA_W = 64;
  localparam int STATUS_W = 2;
  localparam int DONE_W = 4;
  localparam int BYTE_W = 8;
  localparam int MAX_XFER = 8;

  localparam logic [OP_W-1:0] OP_ERASE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_WRITTEN = 2'd3;

  localparam logic [BYTE_W-1:0] RESET_FILL = 8'hFF;

endpackage

// File: hw/rtl/fam_if.sv
interface fam_cmd_if
  import fam_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] opcode;
  logic [ADDR_W-1:0] address;
  logic [COUNT_W-1:0] count;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, opcode, address, count, write_data, input ready);
  modport sink (input valid, opcode, address, count, write_data, output ready);
endinterface

interface fam_rsp_if
  import fam_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0] read_data;
  logic [DONE_W-1:0] done_size;

  modport source (output valid, status, read_data, done_size, input ready);
  modport sink (input valid, status, read_data, done_size, output ready);
endinterface

interface fam_cfg_if
  import fam_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [BYTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/flash_array_model_top.sv
// Read and write: a registered byte-lane memory read at accept, then check and write back in
// CHECK, which waits while the output is full; one item at a time; the next item is taken
// once the result is loaded. Erase: the result is loaded from CHECK, then the array is busy
// sweeping count * SECTOR_BYTES / 8 rows, writing one row of the eight byte lanes per cycle.
// Reset (synchronous): a clearing pass over all ROWS (512) rows fills the array with 0xFF;
// no item is taken until it ends; erased_value resets to 0xFF.
module flash_array_model_top
  import fam_pkg::*;
(
  input logic clk,
  input logic rst,
  fam_cmd_if.sink cmd,
  fam_rsp_if.source rsp,
  fam_cfg_if.sink cfg
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_ERASE = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;
  localparam int EW = ADDR_W + COUNT_W;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [ROW_W-1:0] ptr;
  logic [ROW_W-1:0] ptr_next;
  logic [ROW_W-1:0] last;
  logic [ROW_W-1:0] last_next;
  logic [BYTE_W-1:0] erased_value;

  logic [OP_W-1:0] op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [DATA_W-1:0] wdata_q;

  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0] out_data;
  logic [DONE_W-1:0] out_done;

  logic accept;
  logic load;
  logic [STATUS_W-1:0] status_c;
  logic [DATA_W-1:0] rdata_c;
  logic [DONE_W-1:0] done_c;
  logic wr_ok;
  logic erase_go;

  logic [BYTE_W-1:0] bank_rdata [LANES];
  logic [ROW_W-1:0] bank_raddr [LANES];
  logic [ROW_W-1:0] bank_waddr [LANES];
  logic [BYTE_W-1:0] bank_wdata [LANES];
  logic bank_we [LANES];

  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign load = (state == ST_CHECK) && (!out_valid || rsp.ready);

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.read_data = out_data;
  assign rsp.done_size = out_done;

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      fam_ram u_ram (
        .clk   (clk),
        .we    (bank_we[g]),
        .waddr (bank_waddr[g]),
        .wdata (bank_wdata[g]),
        .re    (accept),
        .raddr (bank_raddr[g]),
        .rdata (bank_rdata[g])
      );
    end
  endgenerate

  always_comb begin
    logic [ROW_W-1:0] row_a;
    logic [LANE_W-1:0] a0;
    row_a = ROW_W'(cmd.address >> LANE_W);
    a0 = cmd.address[LANE_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      bank_raddr[l] = (LANE_W'(l) >= a0) ? row_a : row_a + 1'b1;
    end
  end

  // check the latched item against the lane data
  always_comb begin
    logic [BYTE_W-1:0] rd_bytes [LANES];
    logic [LANE_W-1:0] a0;
    logic [ADDR_W:0] end_addr;
    logic [ADDR_W:0] sect_end;
    logic [ADDR_W:0] sect_fill;
    logic written;
    logic xfer_big;
    logic [DATA_W-1:0] rd_word;
    a0 = addr_q[LANE_W-1:0];
    end_addr = (ADDR_W+1)'(addr_q) + (ADDR_W+1)'(cnt_q);
    sect_end = (ADDR_W+1)'(addr_q >> SECT_OFF_W) + (ADDR_W+1)'(cnt_q);
    sect_fill = (ADDR_W+1)'(addr_q % SECTOR_BYTES) + (ADDR_W+1)'(cnt_q);
    xfer_big = (cnt_q > COUNT_W'(MAX_XFER));
    written = 1'b0;
    rd_word = '0;
    for (int i = 0; i < LANES; i++) begin
      rd_bytes[i] = bank_rdata[LANE_W'(a0 + LANE_W'(i))];
      if (COUNT_W'(i) < cnt_q) begin
        rd_word[i*BYTE_W +: BYTE_W] = rd_bytes[i];
        if (rd_bytes[i] != erased_value) begin
          written = 1'b1;
        end
      end
    end
    status_c = STAT_INVALID;
    rdata_c = '0;
    done_c = '0;
    wr_ok = 1'b0;
    erase_go = 1'b0;
    unique case (op_q)
      OP_ERASE: begin
        if ((addr_q % SECTOR_BYTES) != 0) begin
          status_c = STAT_INVALID;
        end else if (sect_end > (ADDR_W+1)'(SECTOR_TOTAL)) begin
          status_c = STAT_RANGE;
        end else begin
          status_c = STAT_OK;
          erase_go = (cnt_q != '0);
        end
      end
      OP_READ: begin
        if (xfer_big) begin
          status_c = STAT_INVALID;
        end else if (end_addr > (ADDR_W+1)'(ARRAY_BYTES)) begin
          status_c = STAT_RANGE;
        end else begin
          status_c = STAT_OK;
          rdata_c = rd_word;
          done_c = DONE_W'(cnt_q);
        end
      end
      OP_WRITE: begin
        if (xfer_big) begin
          status_c = STAT_INVALID;
        end else if ((addr_q % ALIGN_BYTES) != 0 || (cnt_q % ALIGN_BYTES) != 0) begin
          status_c = STAT_INVALID;
        end else if (sect_fill > (ADDR_W+1)'(SECTOR_BYTES)) begin
          status_c = STAT_INVALID;
        end else if (end_addr > (ADDR_W+1)'(ARRAY_BYTES)) begin
          status_c = STAT_RANGE;
        end else if (written) begin
          status_c = STAT_WRITTEN;
        end else begin
          status_c = STAT_OK;
          done_c = DONE_W'(cnt_q);
          wr_ok = 1'b1;
        end
      end
      default: begin
        status_c = STAT_INVALID;
      end
    endcase
  end

  always_comb begin
    logic [ROW_W-1:0] row_q;
    logic [LANE_W-1:0] a0;
    logic [LANE_W-1:0] idx;
    row_q = ROW_W'(addr_q >> LANE_W);
    a0 = addr_q[LANE_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      idx = LANE_W'(l) - a0;
      bank_we[l] = 1'b0;
      bank_waddr[l] = ptr;
      bank_wdata[l] = (state == ST_CLEAR) ? RESET_FILL : erased_value;
      if (state == ST_ERASE || state == ST_CLEAR) begin
        bank_we[l] = 1'b1;
      end else if (load && wr_ok && (COUNT_W'(idx) < cnt_q)) begin
        bank_we[l] = 1'b1;
        bank_waddr[l] = (LANE_W'(l) >= a0) ? row_q : row_q + 1'b1;
        bank_wdata[l] = wdata_q[idx*BYTE_W +: BYTE_W];
      end
    end
  end

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    last_next = last;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (load) begin
          if (erase_go) begin
            state_next = ST_ERASE;
            ptr_next = ROW_W'(addr_q >> LANE_W);
            last_next = ROW_W'(EW'(addr_q >> LANE_W) + EW'(cnt_q) * EW'(ROWS_PER_SECTOR)
                               - EW'(1));
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERASE: begin
        if (ptr == last) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ST_CLEAR: begin
        if (ptr == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr <= '0;
      last <= '0;
      out_valid <= 1'b0;
      erased_value <= RESET_FILL;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      last <= last_next;
      if (cfg.valid && cfg.ready) begin
        erased_value <= cfg.data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= cmd.opcode;
      addr_q <= cmd.address;
      cnt_q <= cmd.count;
      wdata_q <= cmd.write_data;
    end
    if (load) begin
      out_status <= status_c;
      out_data <= rdata_c;
      out_done <= done_c;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CHECK)
    else $error("accepted item did not enter check");

  a_result_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_CHECK)
    else $error("result appeared outside check");

  a_done_means_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.done_size != '0) |-> rsp.status == STAT_OK)
    else $error("nonzero done size with error status");

  a_erase_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ERASE |-> ptr <= last)
    else $error("erase sweep ran past its last row");
`endif

endmodule

// File: hw/rtl/fam_ram.sv
module fam_ram
  import fam_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ROW_W-1:0]  waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [ROW_W-1:0]  raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: test/flash_array_model_top_tb.sv
`timescale 1ns / 1ps

module flash_array_model_top_tb;
  import fam_pkg::*;

  localparam int SETTLE_CYCLES = 600;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 300;
  localparam int MAX_GAP = 17;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ADDR_W-1:0] address;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0] write_data;
  } flash_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0] read_data;
    logic [DONE_W-1:0] done_size;
  } flash_rsp_t;

  logic clk;
  logic rst;

  fam_cmd_if cmd ();
  fam_rsp_if rsp ();
  fam_cfg_if cfg ();

  flash_array_model_top DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp),
    .cfg(cfg)
  );

  logic [BYTE_W-1:0] flash_mem [ARRAY_BYTES];
  logic [BYTE_W-1:0] erased_now;
  flash_cmd_t pending_cmds [$];
  flash_rsp_t expected_rsps [$];
  flash_cmd_t next_cmd;
  flash_rsp_t oldest_rsp;
  int unsigned fail_count;
  int unsigned send_wait;
  int unsigned take_wait;
  int unsigned hot_sector;
  logic calm_send;
  logic calm_take;
  logic cmd_fire;
  logic rsp_fire;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic flash_rsp_t flash_apply(flash_cmd_t c);
    flash_rsp_t r;
    int unsigned a;
    int unsigned n;
    int unsigned i;
    logic dirty;
    r.status = STAT_OK;
    r.read_data = '0;
    r.done_size = '0;
    a = c.address;
    n = c.count;
    dirty = 1'b0;
    case (c.opcode)
      OP_ERASE: begin
        if (a % SECTOR_BYTES != 0) begin
          r.status = STAT_INVALID;
        end else if (a / SECTOR_BYTES + n > SECTOR_TOTAL) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = 0; i < n * SECTOR_BYTES; i++) flash_mem[a + i] = erased_now;
        end
      end
      OP_READ: begin
        if (n > MAX_XFER) begin
          r.status = STAT_INVALID;
        end else if (a + n > ARRAY_BYTES) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = 0; i < n; i++) r.read_data[8*i +: 8] = flash_mem[a + i];
          r.done_size = DONE_W'(n);
        end
      end
      OP_WRITE: begin
        if (n > MAX_XFER) begin
          r.status = STAT_INVALID;
        end else if (a % ALIGN_BYTES != 0 || n % ALIGN_BYTES != 0) begin
          r.status = STAT_INVALID;
        end else if (n > SECTOR_BYTES - a % SECTOR_BYTES) begin
          r.status = STAT_INVALID;
        end else if (a + n > ARRAY_BYTES) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = 0; i < n; i++) if (flash_mem[a + i] != erased_now) dirty = 1'b1;
          if (dirty) begin
            r.status = STAT_WRITTEN;
          end else begin
            for (i = 0; i < n; i++) flash_mem[a + i] = c.write_data[8*i +: 8];
            r.done_size = DONE_W'(n);
          end
        end
      end
      default: begin
        r.status = STAT_INVALID;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned draw_gap(logic calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic queue_cmd(logic [OP_W-1:0] op, int unsigned addr, int unsigned cnt,
                           logic [DATA_W-1:0] data);
    flash_cmd_t c;
    c.opcode = op;
    c.address = ADDR_W'(addr);
    c.count = COUNT_W'(cnt);
    c.write_data = data;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random_item();
    int unsigned pick;
    int unsigned sect;
    int unsigned cnt;
    int unsigned addr;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) hot_sector = $urandom_range(0, SECTOR_TOTAL - 1);
    if (pick < 8) begin
      sect = $urandom_range(0, SECTOR_TOTAL - 1);
      if ($urandom_range(0, 15) == 0) begin
        cnt = $urandom_range(0, SECTOR_TOTAL - sect);
      end else begin
        cnt = (sect < SECTOR_TOTAL - 1) ? $urandom_range(1, 2) : 1;
      end
      hot_sector = sect;
      queue_cmd(OP_ERASE, sect * SECTOR_BYTES, cnt, {$urandom, $urandom});
    end else if (pick < 48) begin
      if ($urandom_range(0, 7) == 0) begin
        cnt = 0;
      end else begin
        cnt = ($urandom_range(0, 2) == 0) ? ALIGN_BYTES : MAX_XFER;
      end
      addr = hot_sector * SECTOR_BYTES
           + $urandom_range(0, SECTOR_BYTES / ALIGN_BYTES - 1) * ALIGN_BYTES;
      queue_cmd(OP_WRITE, addr, cnt, {$urandom, $urandom});
    end else if (pick < 88) begin
      case ($urandom_range(0, 7))
        0: addr = $urandom_range(0, ARRAY_BYTES - 1);
        1: addr = $urandom_range(ARRAY_BYTES - 12, ARRAY_BYTES - 1);
        default: addr = hot_sector * SECTOR_BYTES + $urandom_range(0, SECTOR_BYTES - 1);
      endcase
      queue_cmd(OP_READ, addr, $urandom_range(0, MAX_XFER), {$urandom, $urandom});
    end else begin
      queue_cmd(OP_W'($urandom_range(0, 3)), $urandom_range(0, ARRAY_BYTES - 1),
                $urandom_range(0, 31), {$urandom, $urandom});
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd.valid || expected_rsps.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_erased_value(logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    erased_now = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // send side
  always @(negedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd_fire) begin
      if (send_wait != 0) begin
        cmd.valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        cmd.valid <= 1'b1;
        cmd.opcode <= next_cmd.opcode;
        cmd.address <= next_cmd.address;
        cmd.count <= next_cmd.count;
        cmd.write_data <= next_cmd.write_data;
        if ($urandom_range(0, 63) == 0) calm_send <= !calm_send;
        send_wait <= draw_gap(calm_send);
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // receive side
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rsp_fire) begin
      if ($urandom_range(0, 63) == 0) calm_take <= !calm_take;
      take_wait = draw_gap(calm_take);
      rsp.ready <= (take_wait == 0);
    end else if (take_wait != 0) begin
      take_wait = take_wait - 1;
      rsp.ready <= (take_wait == 0);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_fire <= 1'b0;
      rsp_fire <= 1'b0;
    end else begin
      cmd_fire <= cmd.valid && cmd.ready;
      rsp_fire <= rsp.valid && rsp.ready;
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result: status %0d read_data %h done_size %0d",
                     rsp.status, rsp.read_data, rsp.done_size);
          end
        end else begin
          oldest_rsp = expected_rsps.pop_front();
          if (rsp.status !== oldest_rsp.status || rsp.read_data !== oldest_rsp.read_data ||
              rsp.done_size !== oldest_rsp.done_size) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("mismatch: expected status %0d read_data %h done_size %0d",
                       oldest_rsp.status, oldest_rsp.read_data, oldest_rsp.done_size);
              $display("          actual   status %0d read_data %h done_size %0d",
                       rsp.status, rsp.read_data, rsp.done_size);
            end
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        expected_rsps.push_back(flash_apply(flash_cmd_t'{cmd.opcode, cmd.address, cmd.count,
                                                         cmd.write_data}));
      end
    end
  end

  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.opcode = OP_ERASE;
    cmd.address = '0;
    cmd.count = '0;
    cmd.write_data = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    erased_now = RESET_FILL;
    foreach (flash_mem[i]) flash_mem[i] = RESET_FILL;
    fail_count = 0;
    send_wait = 0;
    take_wait = 0;
    hot_sector = 0;
    calm_send = 1'b0;
    calm_take = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_cmd(OP_READ, 0, 8, '0);
    queue_cmd(OP_WRITE, 0, 8, 64'h0123_4567_89AB_CDEF);
    queue_cmd(OP_READ, 0, 8, '0);
    queue_cmd(OP_WRITE, 4, 4, 64'h1111_2222_3333_4444);
    queue_cmd(OP_WRITE, 2, 4, 64'h5555_6666_7777_8888);
    queue_cmd(OP_WRITE, 8, 6, 64'h9999_AAAA_BBBB_CCCC);
    queue_cmd(OP_WRITE, 252, 8, 64'hDDDD_EEEE_0000_1111);
    queue_cmd(OP_WRITE, 16, 12, 64'h2222_3333_4444_5555);
    queue_cmd(OP_WRITE, 32, 0, 64'h6666_7777_8888_9999);
    queue_cmd(OP_WRITE, ARRAY_BYTES - 4, 4, '1);
    queue_cmd(OP_WRITE, 256, 8, '0);
    queue_cmd(OP_READ, ARRAY_BYTES - 8, 8, '0);
    queue_cmd(OP_READ, ARRAY_BYTES - 6, 8, '0);
    queue_cmd(OP_READ, ARRAY_BYTES - 1, 0, '0);
    queue_cmd(OP_READ, 0, 31, '0);
    queue_cmd(OP_W'(3), ARRAY_BYTES - 1, 31, '1);
    queue_cmd(OP_ERASE, 5, 1, '0);
    queue_cmd(OP_ERASE, (SECTOR_TOTAL - 1) * SECTOR_BYTES, 2, '0);
    queue_cmd(OP_ERASE, 0, 0, '0);
    queue_cmd(OP_READ, 256, 8, '0);
    queue_cmd(OP_ERASE, 256, 1, '0);
    queue_cmd(OP_READ, 256, 8, '0);
    queue_cmd(OP_ERASE, 0, SECTOR_TOTAL, '0);
    queue_cmd(OP_READ, 0, 8, '0);
    queue_cmd(OP_ERASE, 0, 31, '0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0, 3: set_erased_value(8'h00);
        2: set_erased_value(BYTE_W'($urandom_range(1, 254)));
        default: set_erased_value(8'hFF);
      endcase
      repeat (PHASE_ITEMS) queue_random_item();
    end

    wait_drained();
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fam_pkg.sv
hw/rtl/fam_if.sv
hw/rtl/fam_ram.sv
hw/rtl/flash_array_model_top.sv
test/flash_array_model_top_tb.sv
